/* rtl/core/lsrc_pkg.sv */
`timescale 1ns / 1ps

package lsrc_pkg;

   localparam int PIXEL_W = 8;
   localparam int COUNT_W = 12;
   localparam int WSUM_W  = 32;
   localparam int ISUM_W  = 20;
   localparam int PROD_W  = COUNT_W + PIXEL_W;

   // Counters and the reported column never exceed the 12-bit field
   localparam int CNT_LIMIT = 4095;

   localparam logic [WSUM_W-1:0] WSUM_MAX = {WSUM_W{1'b1}};
   localparam logic [ISUM_W-1:0] ISUM_MAX = {ISUM_W{1'b1}};

   localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'd100;

   // Row jobs waiting between the accumulator and the divider
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               end_of_row;
      logic               end_of_frame;
   } req_beat_type;

   typedef struct packed {
      logic [COUNT_W-1:0] row_index;
      logic [COUNT_W-1:0] center_column;
      logic               line_found;
   } rsp_beat_type;

   // One finished row: sums to be divided
   typedef struct packed {
      logic [COUNT_W-1:0] row_index;
      logic [WSUM_W-1:0]  weighted_sum;
      logic [ISUM_W-1:0]  intensity_sum;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

endpackage

/* rtl/core/lsrc_if.sv */
`timescale 1ns / 1ps

interface lsrc_req_if;
   logic                  valid;
   logic                  ready;
   lsrc_pkg::req_beat_type beat;

   modport source (output valid, output beat, input ready);
   modport sink   (input valid, input beat, output ready);
endinterface

interface lsrc_rsp_if;
   logic                  valid;
   logic                  ready;
   lsrc_pkg::rsp_beat_type beat;

   modport source (output valid, output beat, input ready);
   modport sink   (input valid, input beat, output ready);
endinterface

/* rtl/core/lsrc_front.sv */
`timescale 1ns / 1ps

module lsrc_front #(
   parameter logic [11:0] COL_CAP = 12'd4095,
   parameter logic [11:0] ROW_CAP = 12'd4095
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [7:0]            csr_wdata,
   lsrc_req_if.sink              req,
   input  logic                  queue_full,
   output lsrc_pkg::push_type    push
);
   import lsrc_pkg::*;

   logic [PIXEL_W-1:0] threshold_ff;
   logic [COUNT_W-1:0] col_ff, col_in;
   logic [COUNT_W-1:0] row_ff, row_in;
   logic [WSUM_W-1:0]  wsum_ff, wsum_in;
   logic [ISUM_W-1:0]  isum_ff, isum_in;

   logic               accept;
   logic               row_end;
   logic [PIXEL_W-1:0] px_kept;
   logic [PROD_W-1:0]  prod;
   logic [WSUM_W:0]    wsum_wide;
   logic [ISUM_W:0]    isum_wide;
   logic [WSUM_W-1:0]  wsum_sat;
   logic [ISUM_W-1:0]  isum_sat;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign row_end   = req.beat.end_of_row || req.beat.end_of_frame;

   assign px_kept   = (req.beat.pixel > threshold_ff) ? req.beat.pixel : '0;
   assign prod      = PROD_W'(col_ff) * PROD_W'(px_kept);
   assign wsum_wide = {1'b0, wsum_ff} + (WSUM_W + 1)'(prod);
   assign isum_wide = {1'b0, isum_ff} + (ISUM_W + 1)'(px_kept);
   assign wsum_sat  = wsum_wide[WSUM_W] ? WSUM_MAX : wsum_wide[WSUM_W-1:0];
   assign isum_sat  = isum_wide[ISUM_W] ? ISUM_MAX : isum_wide[ISUM_W-1:0];

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      wsum_in = wsum_ff;
      isum_in = isum_ff;
      if (accept) begin
         if (row_end) begin
            col_in  = '0;
            wsum_in = '0;
            isum_in = '0;
            if (req.beat.end_of_frame) begin
               row_in = '0;
            end else if (row_ff < ROW_CAP) begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            wsum_in = wsum_sat;
            isum_in = isum_sat;
            if (col_ff < COL_CAP) begin
               col_in = col_ff + 1'b1;
            end
         end
      end
   end

   assign push.valid             = accept && row_end;
   assign push.job.row_index     = row_ff;
   assign push.job.weighted_sum  = wsum_sat;
   assign push.job.intensity_sum = isum_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         wsum_ff      <= '0;
         isum_ff      <= '0;
      end else begin
         if (csr_we) begin
            threshold_ff <= csr_wdata;
         end
         col_ff  <= col_in;
         row_ff  <= row_in;
         wsum_ff <= wsum_in;
         isum_ff <= isum_in;
      end
   end

endmodule

/* rtl/core/lsrc_queue.sv */
`timescale 1ns / 1ps

module lsrc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  lsrc_pkg::push_type    push,
   output logic                  full,
   output logic                  job_valid,
   output lsrc_pkg::job_type     job,
   input  logic                  pop
);
   import lsrc_pkg::*;

   job_type             store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign job_valid = (count_ff != '0);
   assign job       = store_ff[rd_ptr_ff];
   assign do_pop    = pop && job_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push.valid, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         store_ff[wr_ptr_ff] <= push.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push.valid || do_pop)
      else $error("row job pushed into full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      push.valid |=> job_valid)
      else $error("pushed job not visible");

endmodule

/* rtl/core/lsrc_back.sv */
`timescale 1ns / 1ps

module lsrc_back #(
   parameter logic [11:0] COL_CAP = 12'd4095
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  lsrc_pkg::job_type     job,
   output logic                  pop,
   lsrc_rsp_if.source            rsp
);
   import lsrc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam int STEP_W = $clog2(WSUM_W);

   logic [1:0]          st_ff, st_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [ISUM_W-1:0]   rem_ff, rem_in;
   logic [WSUM_W-1:0]   quo_ff, quo_in;
   logic [ISUM_W-1:0]   divisor_ff;
   logic [COUNT_W-1:0]  row_ff;

   logic                out_valid_ff, out_valid_in;
   rsp_beat_type        out_ff;

   logic [ISUM_W:0]     trial;
   logic                fits;
   logic                load_out;
   logic                found;
   logic [COUNT_W-1:0]  center;

   assign pop   = (st_ff == ST_IDLE) && job_valid;
   assign trial = {rem_ff, quo_ff[WSUM_W-1]};
   assign fits  = (trial >= {1'b0, divisor_ff});

   assign found    = (divisor_ff != '0);
   assign center   = !found ? '0 :
                     (quo_ff > WSUM_W'(COL_CAP)) ? COL_CAP : quo_ff[COUNT_W-1:0];
   assign load_out = (st_ff == ST_DONE) && (!out_valid_ff || rsp.ready);

   always_comb begin
      st_in   = st_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (job_valid) begin
               st_in   = ST_DIV;
               step_in = '0;
               rem_in  = '0;
               quo_in  = job.weighted_sum;
            end
         end
         ST_DIV: begin
            rem_in  = fits ? ISUM_W'(trial - {1'b0, divisor_ff}) : trial[ISUM_W-1:0];
            quo_in  = {quo_ff[WSUM_W-2:0], fits};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(WSUM_W - 1)) begin
               st_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (load_out) begin
         out_valid_in = 1'b1;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.beat  = out_ff;

   always_ff @(posedge clock) begin
      if (pop) begin
         divisor_ff <= job.intensity_sum;
         row_ff     <= job.row_index;
      end
      if (load_out) begin
         out_ff.row_index     <= row_ff;
         out_ff.center_column <= center;
         out_ff.line_found    <= found;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_pop_starts_div: assert property (@(posedge clock) disable iff (reset)
      pop |=> st_ff == ST_DIV)
      else $error("popped job did not start division");

   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_DIV) && (step_ff == STEP_W'(WSUM_W - 1)) |=> st_ff == ST_DONE)
      else $error("division did not finish after last step");

   a_empty_row_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.beat.line_found |-> rsp.beat.center_column == '0)
      else $error("empty row reports nonzero column");

   a_center_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.beat.center_column <= COL_CAP)
      else $error("center column above cap");

endmodule

/* rtl/core/laser_stripe_row_centroid_top.sv */
`timescale 1ns / 1ps

// Laser stripe centre per row by gray centroid. Pixels arrive as req beats in
// row-major order; each one is zeroed unless strictly above the threshold
// register (reset 100, written through csr_we/csr_wdata by the user only
// while idle; the block does not enforce it). At a beat flagged end_of_row
// or end_of_frame one rsp beat comes out: row index, floor(sum col*pixel /
// sum pixel) clamped to MAX_COLS-1, and line_found=0 with column 0 when no
// pixel survived. Rate: within a row one pixel per cycle while the job
// queue is not full. Each finished row goes through a bit-serial divider,
// one quotient bit per cycle over the 32-bit weighted sum; a two-row job
// queue absorbs bursts, and short rows back-pressure req when it fills.
// Reset is synchronous, active high, and needs no clearing pass.
module laser_stripe_row_centroid_top #(
   parameter int MAX_COLS = 4096,
   parameter int MAX_ROWS = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [7:0]   csr_wdata,
   lsrc_req_if.sink     req_chan,
   lsrc_rsp_if.source   rsp_chan
);
   import lsrc_pkg::*;

   // Counter caps: parameter minus one, never beyond the 12-bit fields
   localparam int COL_CAP_INT = (MAX_COLS - 1 < CNT_LIMIT) ? MAX_COLS - 1 : CNT_LIMIT;
   localparam int ROW_CAP_INT = (MAX_ROWS - 1 < CNT_LIMIT) ? MAX_ROWS - 1 : CNT_LIMIT;
   localparam logic [COUNT_W-1:0] COL_CAP = COUNT_W'(COL_CAP_INT);
   localparam logic [COUNT_W-1:0] ROW_CAP = COUNT_W'(ROW_CAP_INT);

   push_type  push;
   logic      queue_full;
   logic      job_valid;
   job_type   job;
   logic      pop;

   // Front: threshold and per-row accumulation, one pixel a cycle unless the queue is full
   lsrc_front #(
      .COL_CAP (COL_CAP),
      .ROW_CAP (ROW_CAP)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req        (req_chan),
      .queue_full (queue_full),
      .push       (push)
   );

   // Finished-row jobs; lets accumulation run on while a divide is in flight
   lsrc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (queue_full),
      .job_valid (job_valid),
      .job       (job),
      .pop       (pop)
   );

   // Back: serial divide, clamp, output register
   lsrc_back #(
      .COL_CAP (COL_CAP)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .pop       (pop),
      .rsp       (rsp_chan)
   );

endmodule

/* tb/tb_laser_stripe_row_centroid_top.sv */
`timescale 1ns / 1ps

// Predicts one centroid beat per finished row and matches rsp beats in order.
class centroid_scoreboard;
   logic [7:0]  threshold;
   logic [11:0] column_count;
   logic [11:0] row_count;
   logic [31:0] weighted_sum;
   logic [19:0] intensity_sum;
   int unsigned col_cap;
   int unsigned row_cap;
   int unsigned errors;
   lsrc_pkg::rsp_beat_type centroids_due[$];

   function new(int unsigned max_cols, int unsigned max_rows);
      col_cap = (max_cols - 1 < lsrc_pkg::CNT_LIMIT) ? max_cols - 1 : lsrc_pkg::CNT_LIMIT;
      row_cap = (max_rows - 1 < lsrc_pkg::CNT_LIMIT) ? max_rows - 1 : lsrc_pkg::CNT_LIMIT;
      threshold     = lsrc_pkg::THRESHOLD_RESET;
      column_count  = '0;
      row_count     = '0;
      weighted_sum  = '0;
      intensity_sum = '0;
      errors        = 0;
   endfunction

   function void set_threshold(logic [7:0] value);
      threshold = value;
   endfunction

   task report(string what);
      errors++;
      $display("MISMATCH: %s", what);
   endtask

   function void note_pixel(lsrc_pkg::req_beat_type b);
      logic [7:0]  kept;
      logic [63:0] w;
      logic [63:0] s;
      logic [63:0] q;
      lsrc_pkg::rsp_beat_type c;
      kept = (b.pixel > threshold) ? b.pixel : 8'd0;
      w = 64'(weighted_sum) + 64'(column_count) * 64'(kept);
      s = 64'(intensity_sum) + 64'(kept);
      weighted_sum  = (w > 64'(lsrc_pkg::WSUM_MAX)) ? lsrc_pkg::WSUM_MAX : w[31:0];
      intensity_sum = (s > 64'(lsrc_pkg::ISUM_MAX)) ? lsrc_pkg::ISUM_MAX : s[19:0];
      if (!b.end_of_row && !b.end_of_frame) begin
         if (column_count < col_cap) column_count = column_count + 12'd1;
         return;
      end
      c.row_index = row_count;
      if (intensity_sum != 0) begin
         q = 64'(weighted_sum) / 64'(intensity_sum);
         if (q > 64'(col_cap)) q = 64'(col_cap);
         c.center_column = q[11:0];
         c.line_found    = 1'b1;
      end else begin
         c.center_column = '0;
         c.line_found    = 1'b0;
      end
      centroids_due.push_back(c);
      column_count  = '0;
      weighted_sum  = '0;
      intensity_sum = '0;
      if (b.end_of_frame) row_count = '0;
      else if (row_count < row_cap) row_count = row_count + 12'd1;
   endfunction

   task check_row(lsrc_pkg::rsp_beat_type got);
      lsrc_pkg::rsp_beat_type want;
      if (centroids_due.size() == 0) begin
         report($sformatf("unexpected beat: row %0d col %0d found %0b",
                          got.row_index, got.center_column, got.line_found));
         return;
      end
      want = centroids_due.pop_front();
      if (got.row_index != want.row_index)
         report($sformatf("row_index got %0d want %0d", got.row_index, want.row_index));
      if (got.center_column != want.center_column)
         report($sformatf("center_column got %0d want %0d (row %0d)",
                          got.center_column, want.center_column, want.row_index));
      if (got.line_found != want.line_found)
         report($sformatf("line_found got %0b want %0b (row %0d)",
                          got.line_found, want.line_found, want.row_index));
   endtask
endclass

module tb_laser_stripe_row_centroid_top;
   import lsrc_pkg::*;

   localparam int MAX_COLS     = 4096;
   localparam int MAX_ROWS     = 4096;
   localparam int IDLE_PCT     = 18;
   // drain time for the divider with two rows queued, plus margin
   localparam int DRAIN_CYCLES = 120;
   // worst case: ~1.7k beats, each a one-pixel row costing a full divide
   // under random rsp stalls, plus the drains; a few times over that
   localparam int CYCLE_LIMIT  = 400_000;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [7:0]  csr_wdata;
   bit          quiet;        // suppresses idling on both sides
   int unsigned cycles = 0;

   lsrc_req_if req_chan ();
   lsrc_rsp_if rsp_chan ();

   centroid_scoreboard sb;

   laser_stripe_row_centroid_top #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   always #10 clock = ~clock;

   // Watchdog: any hang ends the run as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Result sink: random back-pressure, none while quiet.
   always @(posedge clock) begin
      rsp_chan.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Beat monitor. Both handshakes are sampled at the edge with their pre-edge
   // values; the input beat is noted first so prediction always leads checking.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) sb.note_pixel(req_chan.beat);
         if (rsp_chan.valid && rsp_chan.ready) sb.check_row(rsp_chan.beat);
      end
   end

   // Drive one pixel beat, with random gaps ahead of it, and hold it until taken.
   // valid only gets one NBA per step: either dropped for a gap or set for the beat.
   task automatic push_pixel(input logic [7:0] px, input bit eor, input bit eof);
      req_beat_type b;
      b.pixel        = px;
      b.end_of_row   = eor;
      b.end_of_frame = eof;
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.beat  <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Threshold changes only once every row result is back and the divider has
   // had time to empty. Phases always close on a row end.
   task automatic write_threshold(input logic [7:0] value);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.centroids_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_threshold(value);
   endtask

   // Mostly stripe-shaped rows: a bright band around a random peak on a dim
   // background, some salt noise, an occasional frame end, and a few rows
   // broken by stray end flags mid-row. Last beat of the call always ends a row.
   task automatic random_rows(input int unsigned budget);
      int unsigned sent;
      int unsigned len;
      int unsigned peak;
      int unsigned spread;
      int unsigned k;
      int unsigned pick;
      bit          eor;
      bit          eof;
      logic [7:0]  px;
      sent = 0;
      while (sent < budget) begin
         len    = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 160) : $urandom_range(1, 24);
         peak   = $urandom_range(0, len - 1);
         spread = $urandom_range(0, 4);
         for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < 10) px = 8'($urandom_range(0, 255));
            else if (k + spread >= peak && k <= peak + spread) px = 8'($urandom_range(120, 255));
            else px = 8'($urandom_range(0, 110));
            eor = (k == len - 1);
            eof = 1'b0;
            if (k == len - 1) begin
               pick = $urandom_range(0, 19);
               if (pick < 2) eof = 1'b1;
               else if (pick == 2) begin
                  eor = 1'b0;
                  eof = 1'b1;
               end
            end else if ($urandom_range(0, 99) < 3) begin
               eor = 1'($urandom_range(0, 1));
               eof = 1'($urandom_range(0, 1));
            end
            push_pixel(px, eor, eof);
         end
         sent += len;
      end
   endtask

   initial begin
      int i;
      sb = new(MAX_COLS, MAX_ROWS);
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_wdata      <= '0;
      req_chan.valid <= 1'b0;
      req_chan.beat  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // --- directed, reset threshold of 100 ---
      // at-threshold pixel dropped, one above kept, full scale kept
      push_pixel(8'd0, 1'b0, 1'b0);
      push_pixel(8'd100, 1'b0, 1'b0);
      push_pixel(8'd101, 1'b0, 1'b0);
      push_pixel(8'd255, 1'b1, 1'b0);
      // nothing survives: column 0, not found
      push_pixel(8'd50, 1'b0, 1'b0);
      push_pixel(8'd100, 1'b1, 1'b0);
      // one-pixel row at column 0
      push_pixel(8'd255, 1'b1, 1'b0);
      // frame end without row end closes the row, row index restarts
      push_pixel(8'd200, 1'b0, 1'b0);
      push_pixel(8'd180, 1'b0, 1'b1);
      // both end flags on one beat
      push_pixel(8'd255, 1'b1, 1'b1);
      // symmetric peaks, centroid in the middle
      push_pixel(8'd255, 1'b0, 1'b0);
      for (i = 0; i < 5; i++) push_pixel(8'd0, 1'b0, 1'b0);
      push_pixel(8'd255, 1'b1, 1'b0);

      // threshold at its low end: any nonzero pixel counts
      write_threshold(8'd0);
      push_pixel(8'd1, 1'b0, 1'b0);
      push_pixel(8'd1, 1'b1, 1'b0);
      push_pixel(8'd0, 1'b1, 1'b0);
      // threshold at its high end: nothing can survive
      write_threshold(8'd255);
      push_pixel(8'd255, 1'b0, 1'b0);
      push_pixel(8'd255, 1'b1, 1'b0);

      // --- random rows; first segment runs without any idling ---
      quiet = 1'b1;
      write_threshold(8'($urandom_range(60, 160)));
      random_rows(300);
      quiet = 1'b0;
      write_threshold(8'd0);
      random_rows(280);
      write_threshold(8'd255);
      random_rows(120);
      repeat (3) begin
         write_threshold(8'($urandom_range(0, 255)));
         random_rows(310);
      end

      // --- drain ---
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.centroids_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.centroids_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
